FILE: hdl/dual_motor_speed_ramp_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual motor speed ramp controller
// Shorthand for clocked implications with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_SPEED_RAMP_CONTROLLER_ASSERT_SVH
`define DUAL_MOTOR_SPEED_RAMP_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define DMSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmsr: same-cycle check failed");

// Next-cycle implication.
`define DMSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmsr: next-cycle check failed");

`endif

FILE: hdl/dmsr_pkg.sv
// ----------------------------------------------------------------------------
// dmsr_pkg
// Shared types, codes, constants and helper functions of the dual motor
// speed ramp controller.
// ----------------------------------------------------------------------------
package dmsr_pkg;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_CMD    = 3'd0,
    REQ_TICK   = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_ESTOP  = 3'd3,
    REQ_ECLEAR = 3'd4
  } req_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DEADZONE    = 3'd0,
    REG_TIMEOUT     = 3'd1,
    REG_RAMP_STEP   = 3'd2,
    REG_RAMP_PERIOD = 3'd3,
    REG_MAX_DUTY    = 3'd4
  } reg_idx_e;

  // Bridge direction codes.
  typedef enum logic [1:0] {
    DIR_OFF = 2'd0,
    DIR_FWD = 2'd1,
    DIR_REV = 2'd2
  } dir_e;

  // Status codes.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MOVING = 2'd1,
    ST_ESTOP  = 2'd2
  } status_e;

  // Configuration register reset values.
  localparam logic [6:0]  DEADZONE_RST    = 7'd5;
  localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
  localparam logic [6:0]  RAMP_STEP_RST   = 7'd2;
  localparam logic [9:0]  RAMP_PERIOD_RST = 10'd10;
  localparam logic [15:0] MAX_DUTY_RST    = 16'd255;

  // Division by 100 through a reciprocal: exact for dividends below 2^23.
  localparam logic [23:0] DIV100_MUL   = 24'd10737419;
  localparam int unsigned DIV100_SHIFT = 30;

  // Configuration register bank contents.
  typedef struct packed {
    logic [6:0]  deadzone;
    logic [15:0] timeout_ticks;
    logic [6:0]  ramp_step;
    logic [9:0]  ramp_period;
    logic [15:0] max_duty;
  } cfg_t;

  // Per-item result after the state update.
  typedef struct packed {
    logic signed [7:0] left_speed;
    logic signed [7:0] right_speed;
    logic              timed_out;
    logic              cmd_ignored;
    status_e           status;
  } res_t;

  // Deadzone and clamp of a raw speed command.
  function automatic logic signed [7:0] shape_cmd(input logic signed [15:0] c,
                                                  input logic [6:0] dz);
    logic [16:0] mag;
    mag = c[15] ? (17'd0 - {1'b1, c}) : {1'b0, c};
    if (mag < {10'd0, dz}) begin
      shape_cmd = 8'sd0;
    end else if (c > 16'sd100) begin
      shape_cmd = 8'sd100;
    end else if (c < -16'sd100) begin
      shape_cmd = -8'sd100;
    end else begin
      shape_cmd = c[7:0];
    end
  endfunction

  // One ramp update: move toward the target by the step, or snap to it.
  function automatic logic signed [7:0] ramp_one(input logic signed [7:0] speed,
                                                 input logic signed [7:0] target,
                                                 input logic [6:0] step);
    logic signed [8:0] diff;
    logic [8:0]        mag;
    diff = {target[7], target} - {speed[7], speed};
    mag  = diff[8] ? (9'd0 - diff) : diff;
    if (mag > {2'd0, step}) begin
      ramp_one = diff[8] ? (speed - $signed({1'b0, step}))
                         : (speed + $signed({1'b0, step}));
    end else begin
      ramp_one = target;
    end
  endfunction

endpackage

FILE: hdl/dmsr_cfg.sv
// ----------------------------------------------------------------------------
// dmsr_cfg
// Configuration register bank, written one register per handshake.
// ----------------------------------------------------------------------------
module dmsr_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [2:0]         wr_index_i,
  input  logic [15:0]        wr_data_i,
  output dmsr_pkg::cfg_t     cfg_o
);

  dmsr_pkg::cfg_t cfg_q;
  dmsr_pkg::cfg_t cfg_d;

  // Decode the register index; unknown indexes leave the bank alone.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        dmsr_pkg::REG_DEADZONE:    cfg_d.deadzone      = wr_data_i[6:0];
        dmsr_pkg::REG_TIMEOUT:     cfg_d.timeout_ticks = wr_data_i;
        dmsr_pkg::REG_RAMP_STEP:   cfg_d.ramp_step     = wr_data_i[6:0];
        dmsr_pkg::REG_RAMP_PERIOD: cfg_d.ramp_period   = wr_data_i[9:0];
        dmsr_pkg::REG_MAX_DUTY:    cfg_d.max_duty      = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone      <= dmsr_pkg::DEADZONE_RST;
      cfg_q.timeout_ticks <= dmsr_pkg::TIMEOUT_RST;
      cfg_q.ramp_step     <= dmsr_pkg::RAMP_STEP_RST;
      cfg_q.ramp_period   <= dmsr_pkg::RAMP_PERIOD_RST;
      cfg_q.max_duty      <= dmsr_pkg::MAX_DUTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/dmsr_ctrl.sv
// ----------------------------------------------------------------------------
// dmsr_ctrl
// Controller state: targets, speeds, emergency latch, command timeout and
// ramp divider. Updated in the cycle an item is accepted.
// ----------------------------------------------------------------------------
module dmsr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dmsr_pkg::cfg_t     cfg_i,
  input  logic               accept_i,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] left_cmd_i,
  input  logic signed [15:0] right_cmd_i,
  output dmsr_pkg::res_t     res_o
);

  logic signed [7:0] left_speed_q, left_speed_d;
  logic signed [7:0] right_speed_q, right_speed_d;
  logic signed [7:0] left_target_q, left_target_d;
  logic signed [7:0] right_target_q, right_target_d;
  logic              latched_q, latched_d;
  logic              armed_q, armed_d;
  logic [15:0]       age_q, age_d;
  logic [9:0]        ramp_cnt_q, ramp_cnt_d;
  logic              timed_out;
  logic              ignored;
  logic [15:0]       age_inc;
  logic [9:0]        cnt_inc;

  // Next-state logic for one request.
  always_comb begin
    left_speed_d   = left_speed_q;
    right_speed_d  = right_speed_q;
    left_target_d  = left_target_q;
    right_target_d = right_target_q;
    latched_d      = latched_q;
    armed_d        = armed_q;
    age_d          = age_q;
    ramp_cnt_d     = ramp_cnt_q;
    timed_out      = 1'b0;
    ignored        = 1'b0;
    age_inc        = (age_q == 16'hFFFF) ? age_q : (age_q + 16'd1);
    cnt_inc        = ramp_cnt_q + 10'd1;

    unique case (req_type_i)
      dmsr_pkg::REQ_CMD: begin
        if (latched_q) begin
          ignored = 1'b1;
        end else begin
          left_target_d  = dmsr_pkg::shape_cmd(left_cmd_i, cfg_i.deadzone);
          right_target_d = dmsr_pkg::shape_cmd(right_cmd_i, cfg_i.deadzone);
          armed_d        = 1'b1;
          age_d          = 16'd0;
        end
      end
      dmsr_pkg::REQ_TICK: begin
        // Age the last command and stop once when it grows too old.
        if (armed_q) begin
          age_d = age_inc;
          if (age_inc > cfg_i.timeout_ticks) begin
            left_speed_d   = 8'sd0;
            right_speed_d  = 8'sd0;
            left_target_d  = 8'sd0;
            right_target_d = 8'sd0;
            armed_d        = 1'b0;
            timed_out      = 1'b1;
          end
        end
        // Ramp divider; a wrap to zero also fires the update.
        ramp_cnt_d = cnt_inc;
        if ((cnt_inc >= cfg_i.ramp_period) || (cnt_inc == 10'd0)) begin
          ramp_cnt_d    = 10'd0;
          left_speed_d  = dmsr_pkg::ramp_one(left_speed_d, left_target_d,
                                             cfg_i.ramp_step);
          right_speed_d = dmsr_pkg::ramp_one(right_speed_d, right_target_d,
                                             cfg_i.ramp_step);
        end
      end
      dmsr_pkg::REQ_STOP: begin
        left_speed_d   = 8'sd0;
        right_speed_d  = 8'sd0;
        left_target_d  = 8'sd0;
        right_target_d = 8'sd0;
      end
      dmsr_pkg::REQ_ESTOP: begin
        latched_d      = 1'b1;
        left_speed_d   = 8'sd0;
        right_speed_d  = 8'sd0;
        left_target_d  = 8'sd0;
        right_target_d = 8'sd0;
      end
      dmsr_pkg::REQ_ECLEAR: begin
        latched_d = 1'b0;
      end
      default: ;
    endcase
  end

  // State registers, committed only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_speed_q   <= 8'sd0;
      right_speed_q  <= 8'sd0;
      left_target_q  <= 8'sd0;
      right_target_q <= 8'sd0;
      latched_q      <= 1'b0;
      armed_q        <= 1'b0;
      age_q          <= 16'd0;
      ramp_cnt_q     <= 10'd0;
    end else if (accept_i) begin
      left_speed_q   <= left_speed_d;
      right_speed_q  <= right_speed_d;
      left_target_q  <= left_target_d;
      right_target_q <= right_target_d;
      latched_q      <= latched_d;
      armed_q        <= armed_d;
      age_q          <= age_d;
      ramp_cnt_q     <= ramp_cnt_d;
    end
  end

  // Result fields seen after this item.
  always_comb begin
    res_o.left_speed  = left_speed_d;
    res_o.right_speed = right_speed_d;
    res_o.timed_out   = timed_out;
    res_o.cmd_ignored = ignored;
    if (latched_d) begin
      res_o.status = dmsr_pkg::ST_ESTOP;
    end else if ((left_speed_d != 8'sd0) || (right_speed_d != 8'sd0)) begin
      res_o.status = dmsr_pkg::ST_MOVING;
    end else begin
      res_o.status = dmsr_pkg::ST_IDLE;
    end
  end

endmodule

FILE: hdl/dmsr_drive.sv
// ----------------------------------------------------------------------------
// dmsr_drive
// Bridge direction and pwm duty of one wheel, in two pipeline stages:
// magnitude times max duty, then division by 100 through a reciprocal.
// ----------------------------------------------------------------------------
module dmsr_drive (
  input  logic               clk_i,
  input  logic               prod_en_i,
  input  logic               duty_en_i,
  input  logic signed [7:0]  speed_i,
  input  logic [15:0]        max_duty_i,
  output dmsr_pkg::dir_e     dir_o,
  output logic [15:0]        duty_o
);

  logic [7:0]     neg_speed;
  logic [6:0]     mag;
  dmsr_pkg::dir_e dir_d;
  logic [22:0]    prod_d, prod_q;
  dmsr_pkg::dir_e dir_mid_q;
  logic [46:0]    quot;
  logic [15:0]    duty_d, duty_q;
  dmsr_pkg::dir_e dir_q;

  // Sign and magnitude of the speed.
  always_comb begin
    neg_speed = 8'd0 - speed_i;
    mag       = speed_i[7] ? neg_speed[6:0] : speed_i[6:0];
    if (speed_i == 8'sd0) begin
      dir_d = dmsr_pkg::DIR_OFF;
    end else if (speed_i[7]) begin
      dir_d = dmsr_pkg::DIR_REV;
    end else begin
      dir_d = dmsr_pkg::DIR_FWD;
    end
    prod_d = {16'd0, mag} * {7'd0, max_duty_i};
  end

  // Floor division by 100: product is below 2^23, where the reciprocal is exact.
  always_comb begin
    quot   = {24'd0, prod_q} * {23'd0, dmsr_pkg::DIV100_MUL};
    duty_d = quot[dmsr_pkg::DIV100_SHIFT +: 16];
  end

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      prod_q    <= prod_d;
      dir_mid_q <= dir_d;
    end
    if (duty_en_i) begin
      duty_q <= duty_d;
      dir_q  <= dir_mid_q;
    end
  end

  assign dir_o  = dir_q;
  assign duty_o = duty_q;

endmodule

FILE: hdl/dual_motor_speed_ramp_controller.sv
// ----------------------------------------------------------------------------
// dual_motor_speed_ramp_controller
// Two-wheel speed ramp controller with deadzone, clamp, command timeout and
// emergency latch, driving direction and pwm duty for each wheel.
// ----------------------------------------------------------------------------
// Pipeline: a result is valid once its item has passed the state stage,
//   the duty product stage and the divide-by-100 stage.
// Throughput: one item per cycle unless out_stall_i holds a full pipeline.
// Reset: asynchronous; clears all controller state and loads the default
//   configuration.
`include "dual_motor_speed_ramp_controller_assert.svh"

module dual_motor_speed_ramp_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [15:0] left_cmd_i,
  input  logic signed [15:0] right_cmd_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         left_dir_o,
  output logic [15:0]        left_duty_o,
  output logic [1:0]         right_dir_o,
  output logic [15:0]        right_duty_o,
  output logic               timed_out_o,
  output logic               cmd_ignored_o,
  output logic [1:0]         status_o,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  dmsr_pkg::cfg_t    cfg;
  dmsr_pkg::res_t    res;
  dmsr_pkg::res_t    s1_res_q;
  dmsr_pkg::dir_e    left_dir, right_dir;
  logic              s1_v_q, s1_v_d;
  logic              s2_v_q, s2_v_d;
  logic              out_v_q, out_v_d;
  logic              en1, en2, en_out;
  logic              accept;
  logic              s2_timed_out_q, s2_ignored_q;
  dmsr_pkg::status_e s2_status_q;
  logic              out_timed_out_q, out_ignored_q;
  dmsr_pkg::status_e out_status_q;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  dmsr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stage enables: a stage loads when it is empty or its successor loads.
  assign en_out     = !out_v_q || !out_stall_i;
  assign en2        = !s2_v_q || en_out;
  assign en1        = !s1_v_q || en2;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;

  dmsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .left_cmd_i  (left_cmd_i),
    .right_cmd_i (right_cmd_i),
    .res_o       (res)
  );

  // Stage valid bits.
  always_comb begin
    s1_v_d  = en1 ? accept : s1_v_q;
    s2_v_d  = en2 ? s1_v_q : s2_v_q;
    out_v_d = en_out ? s2_v_q : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Flag payload follows the duty pipeline.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
    if (en2) begin
      s2_timed_out_q <= s1_res_q.timed_out;
      s2_ignored_q   <= s1_res_q.cmd_ignored;
      s2_status_q    <= s1_res_q.status;
    end
    if (en_out) begin
      out_timed_out_q <= s2_timed_out_q;
      out_ignored_q   <= s2_ignored_q;
      out_status_q    <= s2_status_q;
    end
  end

  // Per-wheel direction and duty.
  dmsr_drive u_drive_left (
    .clk_i      (clk_i),
    .prod_en_i  (en2),
    .duty_en_i  (en_out),
    .speed_i    (s1_res_q.left_speed),
    .max_duty_i (cfg.max_duty),
    .dir_o      (left_dir),
    .duty_o     (left_duty_o)
  );

  dmsr_drive u_drive_right (
    .clk_i      (clk_i),
    .prod_en_i  (en2),
    .duty_en_i  (en_out),
    .speed_i    (s1_res_q.right_speed),
    .max_duty_i (cfg.max_duty),
    .dir_o      (right_dir),
    .duty_o     (right_duty_o)
  );

  assign out_valid_o   = out_v_q;
  assign left_dir_o    = left_dir;
  assign right_dir_o   = right_dir;
  assign timed_out_o   = out_timed_out_q;
  assign cmd_ignored_o = out_ignored_q;
  assign status_o      = out_status_q;

  // Checks on the pipeline and the result logic.
  `DMSR_ASSERT_IMP(a_stall_only_full, clk_i, rst_ni, in_stall_o, s1_v_q && s2_v_q && out_v_q && out_stall_i)
  `DMSR_ASSERT_NXT(a_accept_loads, clk_i, rst_ni, in_valid_i && !in_stall_o, s1_v_q)
  `DMSR_ASSERT_IMP(a_timeout_halts, clk_i, rst_ni, s1_v_q && s1_res_q.timed_out, s1_res_q.left_speed == 8'sd0 && s1_res_q.right_speed == 8'sd0)
  `DMSR_ASSERT_IMP(a_ignored_latched, clk_i, rst_ni, s1_v_q && s1_res_q.cmd_ignored, s1_res_q.status == dmsr_pkg::ST_ESTOP)
  `DMSR_ASSERT_IMP(a_moving_has_dir, clk_i, rst_ni, out_v_q && out_status_q == dmsr_pkg::ST_MOVING, left_dir != dmsr_pkg::DIR_OFF || right_dir != dmsr_pkg::DIR_OFF)

endmodule

FILE: dv/tb_dual_motor_speed_ramp_controller.sv
// ----------------------------------------------------------------------------
// Testbench for the dual motor speed ramp controller
// Drives request items and register writes, predicts untyped results with
// a behavioral model of the ramp controller kept inside the bench, and checks
// each result field by field. A directed table comes first, then randomized
// phases under several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_dual_motor_speed_ramp_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import dmsr_pkg::*;

  // Request codes that the controller ignores.
  localparam logic [2:0] REQ_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNDEF_LAST  = 3'd7;

  localparam int SPEED_FULL       = 100;
  localparam int NUM_PHASES       = 8;
  localparam int ITEMS_PER_PHASE  = 190;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES     = 8;
  localparam int NUM_REGS         = 5;

  // One result item as the bench expects it.
  typedef struct packed {
    dir_e        left_dir;
    logic [15:0] left_duty;
    dir_e        right_dir;
    logic [15:0] right_duty;
    logic        timed_out;
    logic        cmd_ignored;
    status_e     status;
  } drive_res_t;

  // One row of the directed table: either a register write or an item.
  typedef struct packed {
    logic               cfg_write;
    reg_idx_e           idx;
    logic [15:0]        data;
    logic [2:0]         req;
    logic signed [15:0] lcmd;
    logic signed [15:0] rcmd;
    logic               typed;
    drive_res_t         want;
  } step_row_t;

  localparam drive_res_t RES_IDLE    = '{DIR_OFF, 16'd0, DIR_OFF, 16'd0, 1'b0, 1'b0, ST_IDLE};
  localparam drive_res_t RES_FULL    =
    '{DIR_FWD, 16'd65535, DIR_REV, 16'd65535, 1'b0, 1'b0, ST_MOVING};
  localparam drive_res_t RES_CRAWL   =
    '{DIR_FWD, 16'd655, DIR_REV, 16'd655, 1'b0, 1'b0, ST_MOVING};
  localparam drive_res_t RES_ESTOP   = '{DIR_OFF, 16'd0, DIR_OFF, 16'd0, 1'b0, 1'b0, ST_ESTOP};
  localparam drive_res_t RES_DROPPED = '{DIR_OFF, 16'd0, DIR_OFF, 16'd0, 1'b0, 1'b1, ST_ESTOP};
  localparam drive_res_t RES_TIMEOUT = '{DIR_OFF, 16'd0, DIR_OFF, 16'd0, 1'b1, 1'b0, ST_IDLE};

  localparam int N_DIRECTED = 34;

  // Directed walk: reset behavior, clamping and deadzone edges, full-scale
  // duty, zero ramp period and step, emergency latch, zero timeout.
  localparam step_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{1'b0, REG_DEADZONE, 16'd0, REQ_UNDEF_LAST, 16'sh1234, -16'sd7, 1'b1, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_CMD, 16'sd100, -16'sd100, 1'b1, RES_IDLE},
    '{1'b1, REG_RAMP_PERIOD, 16'd0, REQ_CMD, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b1, REG_RAMP_STEP, 16'd100, REQ_CMD, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b1, REG_MAX_DUTY, 16'd65535, REQ_CMD, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_TICK, 16'sd0, 16'sd0, 1'b1, RES_FULL},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_CMD, 16'sh7FFF, 16'sh8000, 1'b1, RES_FULL},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_CMD, 16'sd4, -16'sd4, 1'b1, RES_FULL},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_TICK, 16'shFFFF, 16'sh5A5A, 1'b1, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_CMD, 16'sd5, -16'sd5, 1'b1, RES_IDLE},
    '{1'b1, REG_RAMP_STEP, 16'd0, REQ_CMD, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_TICK, 16'sd0, 16'sd0, 1'b1, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_ESTOP, 16'sd0, 16'sd0, 1'b1, RES_ESTOP},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_CMD, 16'sd50, 16'sd50, 1'b1, RES_DROPPED},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_TICK, 16'sd0, 16'sd0, 1'b1, RES_ESTOP},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_ECLEAR, 16'sd0, 16'sd0, 1'b1, RES_IDLE},
    '{1'b1, REG_TIMEOUT, 16'd0, REQ_CMD, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b1, REG_RAMP_STEP, 16'd1, REQ_CMD, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_CMD, 16'sh8000, 16'sh7FFF, 1'b1, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_TICK, 16'sd0, 16'sd0, 1'b1, RES_TIMEOUT},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_TICK, 16'sd0, 16'sd0, 1'b1, RES_IDLE},
    '{1'b1, REG_DEADZONE, 16'd0, REQ_CMD, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b1, REG_TIMEOUT, 16'd65535, REQ_CMD, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_CMD, 16'sd1, -16'sd1, 1'b1, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_TICK, 16'sd0, 16'sd0, 1'b1, RES_CRAWL},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_STOP, 16'sd0, 16'sd0, 1'b1, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_CMD, -16'sd101, 16'sd101, 1'b0, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_TICK, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b1, REG_MAX_DUTY, 16'd1, REQ_CMD, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_TICK, 16'sd0, 16'sd0, 1'b0, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_ESTOP, 16'sd0, 16'sd0, 1'b1, RES_ESTOP},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_STOP, 16'sd0, 16'sd0, 1'b1, RES_ESTOP},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_ECLEAR, 16'sd0, 16'sd0, 1'b1, RES_IDLE},
    '{1'b0, REG_DEADZONE, 16'd0, REQ_UNDEF_FIRST, 16'sd0, 16'sd0, 1'b1, RES_IDLE}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         req_type_i;
  logic signed [15:0] left_cmd_i;
  logic signed [15:0] right_cmd_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         left_dir_o;
  logic [15:0]        left_duty_o;
  logic [1:0]         right_dir_o;
  logic [15:0]        right_duty_o;
  logic               timed_out_o;
  logic               cmd_ignored_o;
  logic [1:0]         status_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;

  // Register copy of the bench's controller model.
  logic [6:0]  cfg_deadzone    = DEADZONE_RST;
  logic [15:0] cfg_timeout     = TIMEOUT_RST;
  logic [6:0]  cfg_ramp_step   = RAMP_STEP_RST;
  logic [9:0]  cfg_ramp_period = RAMP_PERIOD_RST;
  logic [15:0] cfg_max_duty    = MAX_DUTY_RST;

  // Controller state of the model.
  logic signed [7:0] spd_l = 8'sd0;
  logic signed [7:0] spd_r = 8'sd0;
  logic signed [7:0] tgt_l = 8'sd0;
  logic signed [7:0] tgt_r = 8'sd0;
  logic              estop_latched = 1'b0;
  logic              timeout_armed = 1'b0;
  logic [15:0]       cmd_age       = 16'd0;
  logic [9:0]        tick_cnt      = 10'd0;

  drive_res_t expected_drive_q [$];

  int  fail_cnt     = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  timeouts     = 0;
  int  dropped_cmds = 0;
  int  reg_writes   = 0;
  int  stall_left   = 0;
  bit  rx_gappy     = 1'b1;
  bit  rx_long_hold = 1'b0;

  dual_motor_speed_ramp_controller DUT (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Deadzone and clamp of one wheel command.
  function automatic logic signed [7:0] shape_speed(input logic signed [15:0] c);
    int v;
    int mag;
    v   = int'(c);
    mag = (v < 0) ? -v : v;
    if (mag < int'(cfg_deadzone)) return 8'sd0;
    if (v > SPEED_FULL) return 8'(SPEED_FULL);
    if (v < -SPEED_FULL) return 8'(-SPEED_FULL);
    return 8'(v);
  endfunction

  // Move a speed toward its target by at most the ramp step.
  function automatic logic signed [7:0] slew(input logic signed [7:0] spd,
                                             input logic signed [7:0] tgt);
    int gap_to_tgt;
    int stp;
    gap_to_tgt = int'(tgt) - int'(spd);
    stp        = int'(cfg_ramp_step);
    if (gap_to_tgt > stp) return 8'(int'(spd) + stp);
    if (gap_to_tgt < -stp) return 8'(int'(spd) - stp);
    return tgt;
  endfunction

  // Bridge direction and pwm duty for one wheel speed.
  function automatic void wheel_out(input logic signed [7:0] spd, output dir_e dir,
                                    output logic [15:0] duty);
    int mag;
    mag = int'(spd);
    if (mag > 0) begin
      dir = DIR_FWD;
    end else if (mag < 0) begin
      dir = DIR_REV;
      mag = -mag;
    end else begin
      dir = DIR_OFF;
    end
    duty = 16'((mag * int'(cfg_max_duty)) / SPEED_FULL);
  endfunction

  function automatic void halt_wheels();
    spd_l = 8'sd0;
    spd_r = 8'sd0;
    tgt_l = 8'sd0;
    tgt_r = 8'sd0;
  endfunction

  // Applies one request item to the model and returns the result it yields.
  function automatic drive_res_t predict_drive(input logic [2:0] req,
                                               input logic signed [15:0] lcmd,
                                               input logic signed [15:0] rcmd);
    drive_res_t res;
    res = RES_IDLE;
    case (req)
      REQ_CMD: begin
        if (estop_latched) begin
          res.cmd_ignored = 1'b1;
        end else begin
          tgt_l         = shape_speed(lcmd);
          tgt_r         = shape_speed(rcmd);
          timeout_armed = 1'b1;
          cmd_age       = 16'd0;
        end
      end
      REQ_TICK: begin
        if (timeout_armed) begin
          if (cmd_age != 16'hFFFF) cmd_age = cmd_age + 16'd1;
          if (cmd_age > cfg_timeout) begin
            halt_wheels();
            timeout_armed = 1'b0;
            res.timed_out = 1'b1;
          end
        end
        // A zero period, or a wrapped counter, ramps on this tick.
        tick_cnt = tick_cnt + 10'd1;
        if (tick_cnt >= cfg_ramp_period || tick_cnt == 10'd0) begin
          tick_cnt = 10'd0;
          spd_l    = slew(spd_l, tgt_l);
          spd_r    = slew(spd_r, tgt_r);
        end
      end
      REQ_STOP: halt_wheels();
      REQ_ESTOP: begin
        estop_latched = 1'b1;
        halt_wheels();
      end
      REQ_ECLEAR: estop_latched = 1'b0;
      default: ;
    endcase
    wheel_out(spd_l, res.left_dir, res.left_duty);
    wheel_out(spd_r, res.right_dir, res.right_duty);
    if (estop_latched) begin
      res.status = ST_ESTOP;
    end else if (spd_l != 8'sd0 || spd_r != 8'sd0) begin
      res.status = ST_MOVING;
    end else begin
      res.status = ST_IDLE;
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Offers one item after a gap, holds it until accepted, then records the
  // expected result (typed in by the caller, or from the model).
  task automatic send_req(input logic [2:0] req, input logic signed [15:0] lcmd,
                          input logic signed [15:0] rcmd, input int gap,
                          input logic typed, input drive_res_t want);
    drive_res_t pred;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    req_type_i  = req;
    left_cmd_i  = lcmd;
    right_cmd_i = rcmd;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_drive(req, lcmd, rcmd);
    expected_drive_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Withdraws the request and waits until every expected result has come.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (expected_drive_q.size() == 0);
  endtask

  // Writes one register while the controller is idle.
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DEADZONE:    cfg_deadzone    = val[6:0];
      REG_TIMEOUT:     cfg_timeout     = val;
      REG_RAMP_STEP:   cfg_ramp_step   = val[6:0];
      REG_RAMP_PERIOD: cfg_ramp_period = val[9:0];
      REG_MAX_DUTY:    cfg_max_duty    = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Wheel command: full 16-bit range, around the clamp, or at the deadzone.
  function automatic logic signed [15:0] rand_speed();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      3: begin
        v = int'(cfg_deadzone) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = int'($urandom_range(0, 240)) - 120;
    endcase
    return 16'(v);
  endfunction

  // Result checker; also picks the stall before the next result.
  always @(posedge clk_i) begin
    drive_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_drive_q.size() == 0) begin
        $error("result arrived with nothing expected");
        fail_cnt++;
      end else begin
        want = expected_drive_q.pop_front();
        check_field("left_dir", want.left_dir, left_dir_o);
        check_field("left_duty", want.left_duty, left_duty_o);
        check_field("right_dir", want.right_dir, right_dir_o);
        check_field("right_duty", want.right_duty, right_duty_o);
        check_field("timed_out", want.timed_out, timed_out_o);
        check_field("cmd_ignored", want.cmd_ignored, cmd_ignored_o);
        check_field("status", want.status, status_o);
        if (want.timed_out) timeouts++;
        if (want.cmd_ignored) dropped_cmds++;
      end
      if ($urandom_range(0, 39) == 0) rx_gappy = !rx_gappy;
      stall_left = rx_gappy ? int'($urandom_range(0, 14)) : 0;
    end
  end

  // Result-side stall driver, including one long hold-off.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        out_stall_i  = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
      end
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Stimulus.
  initial begin
    step_row_t   row;
    logic [15:0] setting [NUM_REGS];
    logic [2:0]  req;
    int          gap;
    int          pick;
    bit          tx_gappy;
    bit          burst;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_CMD;
    left_cmd_i  = 16'sd0;
    right_cmd_i = 16'sd0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_DEADZONE;
    cfg_data_i  = 16'd0;
    tx_gappy    = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table.
    for (int k = 0; k < N_DIRECTED; k++) begin
      row = DIRECTED_ROWS[k];
      if (row.cfg_write) begin
        write_reg(row.idx, row.data);
      end else begin
        gap = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 14)) : 0;
        send_req(row.req, row.lcmd, row.rcmd, gap, row.typed, row.want);
      end
    end

    // Random phases: the first two with fixed low and high register values.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        setting = '{16'd0, 16'd1, 16'd1, 16'd1, 16'd1};
      end else if (ph == 1) begin
        setting = '{16'd100, 16'd65535, 16'd100, 16'd1023, 16'd65535};
      end else begin
        setting[REG_DEADZONE]    = 16'($urandom_range(0, 100));
        setting[REG_TIMEOUT]     = ($urandom_range(0, 3) == 0) ?
                                   16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 40));
        setting[REG_RAMP_STEP]   = ($urandom_range(0, 1) == 1) ?
                                   16'($urandom_range(0, 10)) : 16'($urandom_range(0, 100));
        setting[REG_RAMP_PERIOD] = ($urandom_range(0, 3) == 0) ?
                                   16'($urandom_range(0, 1023)) : 16'($urandom_range(0, 6));
        setting[REG_MAX_DUTY]    = 16'($urandom_range(1, 65535));
      end
      for (int k = 0; k < NUM_REGS; k++) write_reg(reg_idx_e'(k), setting[k]);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 39) == 0) tx_gappy = !tx_gappy;
        // Back-to-back items while the result side is held off.
        burst = (ph == 2 && i > 40 && i < 100);
        gap   = (tx_gappy && !burst) ? int'($urandom_range(0, 14)) : 0;
        pick  = $urandom_range(0, 99);
        if (pick < 35)      req = REQ_CMD;
        else if (pick < 80) req = REQ_TICK;
        else if (pick < 85) req = REQ_STOP;
        else if (pick < 90) req = REQ_ESTOP;
        else if (pick < 97) req = REQ_ECLEAR;
        else                req = 3'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST));
        send_req(req, rand_speed(), rand_speed(), gap, 1'b0, RES_IDLE);
        if (ph == 2 && i == 40) rx_long_hold = 1'b1;
        if (ph == 3 && i == ITEMS_PER_PHASE / 2) drain();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_drive_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_drive_q.size());
      fail_cnt++;
    end
    $display("Sent %0d items under %0d register writes; checked %0d results.",
             items_sent, reg_writes, results_seen);
    $display("Saw %0d command timeouts and %0d commands dropped by the latch.",
             timeouts, dropped_cmds);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
